@@ hw/rtl/crc8fr_pkg.sv @@
`default_nettype none

package crc8fr_pkg;

    localparam logic [7:0] CRC_POLY           = 8'h07;
    localparam logic [7:0] CRC_TOP            = 8'h80;
    localparam logic [7:0] START_MARKER_RESET = 8'hA5;
    localparam logic [7:0] COMMAND_TYPE_RESET = 8'h10;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_COMMAND_TYPE = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BADCRC  = 2'd2,
        EV_TOOLONG = 2'd3
    } frame_evt_t;

    typedef struct packed {
        logic        en;
        logic [31:0] word;
    } push_req_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] count;
    } queue_status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crc8fr_if.sv @@
`default_nettype none

interface crc8fr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface crc8fr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_event;
    logic        cmd_valid;
    logic [31:0] cmd_word;
    logic [3:0]  queue_count;

    modport source (output valid, output frame_event, output cmd_valid, output cmd_word,
                    output queue_count, input ready);
    modport sink (input valid, input frame_event, input cmd_valid, input cmd_word,
                  input queue_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crc8fr_parser.sv @@
`default_nettype none

module crc8fr_parser #(
    parameter int MAX_PAYLOAD = 256,
    parameter int CMD_BYTES   = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_en,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [7:0]           start_marker,
    input  wire logic [7:0]           command_type,
    output crc8fr_pkg::frame_evt_t    evt,
    output crc8fr_pkg::push_req_t     push
);

    localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_TYPE   = 6'b000010,
        PH_LEN_LO = 6'b000100,
        PH_LEN_HI = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CHECK  = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         type_reg, type_next;
    logic [15:0]        length_reg, length_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [7:0]         crc_reg, crc_next;
    logic [31:0]        capture_reg, capture_next;

    always_comb
    begin
        phase_next   = phase_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        index_next   = index_reg;
        crc_next     = crc_reg;
        capture_next = capture_reg;
        evt          = crc8fr_pkg::EV_NONE;
        push.en      = 1'b0;
        push.word    = capture_reg;
        unique case (phase_reg)
            PH_TYPE:
            begin
                type_next  = rx_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {8'h00, rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next  = {rx_byte, length_reg[7:0]};
                index_next   = '0;
                crc_next     = 8'h00;
                capture_next = 32'h0;
                if (length_next == 16'h0000) begin
                    phase_next = PH_CHECK;
                end else if ({1'b0, length_next} > 17'(MAX_PAYLOAD)) begin
                    phase_next = PH_IDLE;
                    evt        = crc8fr_pkg::EV_TOOLONG;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                crc_next = crc8fr_pkg::crc8_update(crc_reg, rx_byte);
                if ((index_reg < IDX_W'(4)) && (index_reg < IDX_W'(CMD_BYTES))) begin
                    capture_next[8*index_reg[1:0] +: 8] = rx_byte;
                end
                index_next = index_reg + IDX_W'(1);
                if ((17'(index_reg) + 17'd1) >= 17'(length_reg)) begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                if (crc_reg == rx_byte) begin
                    evt = crc8fr_pkg::EV_GOOD;
                    if ((type_reg == command_type) && (length_reg == 16'(CMD_BYTES))) begin
                        push.en = 1'b1;
                    end
                end else begin
                    evt = crc8fr_pkg::EV_BADCRC;
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = (rx_byte == start_marker) ? PH_TYPE : PH_IDLE;
            end
        endcase
        if (!byte_en) begin
            evt     = crc8fr_pkg::EV_NONE;
            push.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            type_reg    <= 8'h00;
            length_reg  <= 16'h0000;
            index_reg   <= '0;
            crc_reg     <= 8'h00;
            capture_reg <= 32'h0;
        end else if (byte_en) begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            index_reg   <= index_next;
            crc_reg     <= crc_next;
            capture_reg <= capture_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/crc8fr_cmd_queue.sv @@
`default_nettype none

module crc8fr_cmd_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire crc8fr_pkg::push_req_t      push,
    input  wire logic                       pop_en,
    output crc8fr_pkg::queue_status_t       status,
    output logic [31:0]                     rd_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = PTR_W + 1;

    logic [31:0]      mem [QUEUE_DEPTH];
    logic [31:0]      rd_data_reg;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic [FILL_W-1:0] fill;
    logic             empty;
    logic             full;
    logic             we;
    logic             re;

    assign wp_inc = (wp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc = (rp_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
    assign empty  = (rp_reg == wp_reg);
    assign full   = (wp_inc == rp_reg);
    assign we     = push.en && !full;
    assign re     = pop_en && !empty;

    always_comb
    begin
        wp_next = we ? wp_inc : wp_reg;
        rp_next = re ? rp_inc : rp_reg;
        fill    = FILL_W'(wp_next) - FILL_W'(rp_next)
                  + ((wp_next < rp_next) ? FILL_W'(QUEUE_DEPTH) : '0);
    end

    assign status.hit   = re;
    assign status.count = 4'(fill);
    assign rd_data      = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[wp_reg] <= push.word;
        end
        if (re) begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/crc8_frame_receiver_with_command_fifo.sv @@
// Framed byte receiver with a command queue. Each input beat is either a link
// byte (cmd 0), parsed as marker, type, 16-bit little-endian length, payload and
// a CRC-8 byte (poly 0x07, init 0), or a pop (cmd 1) of the oldest queued
// command. A good frame of the command type and exactly CMD_BYTES long is
// pushed into a QUEUE_DEPTH-slot FIFO that keeps one slot empty; when full the
// command is dropped. Every beat yields one result beat with the frame event,
// the popped command and the fill level. One beat is accepted every clock
// cycle while input ready is high; its result is registered into the output
// register at accept, as is the read of the command store memory. Input ready
// drops only while a result waits in the output register and output ready is
// low. The command store needs no clearing after reset. Configuration:
// start_marker at byte address 0, command_type at byte address 4.
`default_nettype none

module crc8_frame_receiver_with_command_fifo #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 256,
    parameter int CMD_BYTES   = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    crc8fr_in_if.sink        in_ch,
    crc8fr_out_if.source     out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] start_marker_reg;
    logic [7:0] command_type_reg;
    logic       cfg_we;

    logic                      accept;
    crc8fr_pkg::frame_evt_t    evt;
    crc8fr_pkg::push_req_t     push;
    crc8fr_pkg::queue_status_t status;
    logic [31:0]               rd_data;

    logic       out_valid_reg;
    logic [1:0] event_reg;
    logic       cmd_valid_reg;
    logic [3:0] count_reg;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == crc8fr_pkg::REG_COMMAND_TYPE)
                    ? {24'h0, command_type_reg} : {24'h0, start_marker_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_marker_reg <= crc8fr_pkg::START_MARKER_RESET;
            command_type_reg <= crc8fr_pkg::COMMAND_TYPE_RESET;
        end else if (cfg_we) begin
            unique case (paddr[2])
                crc8fr_pkg::REG_START_MARKER: start_marker_reg <= pwdata[7:0];
                crc8fr_pkg::REG_COMMAND_TYPE: command_type_reg <= pwdata[7:0];
                default:                      start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    crc8fr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CMD_BYTES   (CMD_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_en      (accept && !in_ch.cmd),
        .rx_byte      (in_ch.rx_byte),
        .start_marker (start_marker_reg),
        .command_type (command_type_reg),
        .evt          (evt),
        .push         (push)
    );

    crc8fr_cmd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop_en  (accept && in_ch.cmd),
        .status  (status),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            event_reg     <= 2'd0;
            cmd_valid_reg <= 1'b0;
            count_reg     <= 4'd0;
        end else if (in_ch.ready) begin
            out_valid_reg <= accept;
            if (accept) begin
                event_reg     <= evt;
                cmd_valid_reg <= status.hit;
                count_reg     <= status.count;
            end
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.frame_event = event_reg;
    assign out_ch.cmd_valid   = cmd_valid_reg;
    assign out_ch.cmd_word    = cmd_valid_reg ? rd_data : 32'h0;
    assign out_ch.queue_count = count_reg;

endmodule

`default_nettype wire

@@ bench/tb_crc8_frame_receiver_with_command_fifo.sv @@
`default_nettype none

module tb_crc8_frame_receiver_with_command_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_PAYLOAD = 256;
    localparam int CMD_BYTES   = 4;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CHECK
    } parse_ph_t;

    typedef struct packed {
        logic       pop;
        logic [7:0] data;
    } link_beat_t;

    typedef struct packed {
        crc8fr_pkg::frame_evt_t ev;
        logic                   cv;
        logic [31:0]            word;
        logic [3:0]             count;
    } report_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    crc8fr_in_if  in_ch ();
    crc8fr_out_if out_ch ();

    crc8_frame_receiver_with_command_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .CMD_BYTES  (CMD_BYTES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    link_beat_t  link_feed[$];
    report_t     due_reports[$];
    link_beat_t  next_beat;

    logic [7:0]  marker_cfg   = crc8fr_pkg::START_MARKER_RESET;
    logic [7:0]  cmd_type_cfg = crc8fr_pkg::COMMAND_TYPE_RESET;

    parse_ph_t   ph = PH_IDLE;
    logic [7:0]  f_type = '0;
    logic [15:0] f_len = '0;
    int unsigned f_idx = 0;
    logic [7:0]  f_crc = '0;
    logic [31:0] f_capture = '0;
    logic [31:0] cmd_slots[QUEUE_DEPTH];
    logic [3:0]  wr_ptr = '0;
    logic [3:0]  rd_ptr = '0;

    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    int          fails = 0;
    int unsigned cycles = 0;

    always #5 clk = ~clk;

    function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8)
            r = r[7] ? ((r << 1) ^ crc8fr_pkg::CRC_POLY) : (r << 1);
        return r;
    endfunction

    function automatic void frame_parse_step(link_beat_t bt);
        report_t r;
        r.ev    = crc8fr_pkg::EV_NONE;
        r.cv    = 1'b0;
        r.word  = '0;
        r.count = '0;
        if (bt.pop)
        begin
            if (rd_ptr != wr_ptr)
            begin
                r.cv   = 1'b1;
                r.word = cmd_slots[rd_ptr];
                rd_ptr = rd_ptr + 4'd1;
            end
        end
        else
        begin
            case (ph)
                PH_TYPE:
                begin
                    f_type = bt.data;
                    ph     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    f_len = {8'h00, bt.data};
                    ph    = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    f_len     = {bt.data, f_len[7:0]};
                    f_idx     = 0;
                    f_crc     = '0;
                    f_capture = '0;
                    if (f_len == 0)
                        ph = PH_CHECK;
                    else if (f_len > MAX_PAYLOAD)
                    begin
                        ph   = PH_IDLE;
                        r.ev = crc8fr_pkg::EV_TOOLONG;
                    end
                    else
                        ph = PH_DATA;
                end
                PH_DATA:
                begin
                    f_crc = crc8_next(f_crc, bt.data);
                    if (f_idx < 4 && f_idx < CMD_BYTES)
                        f_capture[8 * f_idx +: 8] = bt.data;
                    f_idx++;
                    if (f_idx >= f_len)
                        ph = PH_CHECK;
                end
                PH_CHECK:
                begin
                    if (f_crc == bt.data)
                    begin
                        r.ev = crc8fr_pkg::EV_GOOD;
                        // drop the command silently when the queue is full
                        if (f_type == cmd_type_cfg && f_len == CMD_BYTES
                            && wr_ptr + 4'd1 != rd_ptr)
                        begin
                            cmd_slots[wr_ptr] = f_capture;
                            wr_ptr = wr_ptr + 4'd1;
                        end
                    end
                    else
                        r.ev = crc8fr_pkg::EV_BADCRC;
                    ph = PH_IDLE;
                end
                default:
                    ph = (bt.data == marker_cfg) ? PH_TYPE : PH_IDLE;
            endcase
        end
        r.count = wr_ptr - rd_ptr;
        due_reports.push_back(r);
    endfunction

    function automatic void cmp_field(string fld, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
            fails++;
        end
    endfunction

    function automatic void check_report();
        report_t want;
        if (due_reports.size() == 0)
        begin
            $display({"%0t: result beat with nothing expected, ",
                      "actual event %0d valid %0d word %h count %0d"},
                     $time, out_ch.frame_event, out_ch.cmd_valid, out_ch.cmd_word,
                     out_ch.queue_count);
            fails++;
            return;
        end
        want = due_reports.pop_front();
        cmp_field("frame_event", 32'(want.ev), 32'(out_ch.frame_event));
        cmp_field("cmd_valid", 32'(want.cv), 32'(out_ch.cmd_valid));
        cmp_field("cmd_word", want.word, out_ch.cmd_word);
        cmp_field("queue_count", 32'(want.count), 32'(out_ch.queue_count));
    endfunction

    function automatic void feed(logic pop, logic [7:0] d);
        link_beat_t bt;
        bt.pop  = pop;
        bt.data = d;
        link_feed.push_back(bt);
    endfunction

    // pops land inside frames now and then; parsing must not notice them
    function automatic void feed_link(logic [7:0] b);
        feed(1'b0, b);
        if ($urandom_range(99) < 4)
            feed(1'b1, 8'($urandom));
    endfunction

    function automatic void feed_frame(logic [7:0] ftype, logic [15:0] len, bit bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        feed_link(marker_cfg);
        feed_link(ftype);
        feed_link(len[7:0]);
        feed_link(len[15:8]);
        if (len > MAX_PAYLOAD)
            return;
        for (int i = 0; i < len; i++)
        begin
            b   = 8'($urandom);
            crc = crc8_next(crc, b);
            feed_link(b);
        end
        feed_link(bad_crc ? crc ^ 8'($urandom_range(255, 1)) : crc);
    endfunction

    function automatic void feed_random(int n, int pop_pct);
        int          fed;
        int          sel;
        int          k;
        logic [15:0] len;
        logic [7:0]  b;
        fed = 0;
        while (fed < n)
        begin
            k   = link_feed.size();
            sel = $urandom_range(99);
            if (sel < 45)
                feed_frame(cmd_type_cfg, 16'(CMD_BYTES), 1'b0);
            else if (sel < 55)
                feed_frame(cmd_type_cfg, 16'(CMD_BYTES), 1'b1);
            else if (sel < 67)
                feed_frame(8'($urandom), 16'($urandom_range(8)), $urandom_range(3) == 0);
            else if (sel < 72)
            begin
                len = 16'($urandom_range(8));
                if (len == CMD_BYTES)
                    len = 16'(CMD_BYTES + 1);
                feed_frame(cmd_type_cfg, len, 1'b0);
            end
            else if (sel < 78)
                feed_frame(8'($urandom), 16'($urandom_range(65535, MAX_PAYLOAD + 1)), 1'b0);
            else if (sel < 84)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    b = 8'($urandom);
                    feed(1'b0, (b == marker_cfg) ? ~b : b);
                end
            end
            else if (sel < 88)
                feed(1'b0, marker_cfg);
            else
                repeat ($urandom_range(3, 1))
                    feed(1'b1, 8'($urandom));
            if ($urandom_range(99) < pop_pct)
                feed(1'b1, 8'($urandom));
            fed += link_feed.size() - k;
        end
    endfunction

    task automatic apb_write(logic [2:0] addr, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (link_feed.size() != 0 || in_ch.valid || due_reports.size() != 0);
    endtask

    task automatic set_phase(logic [7:0] mk, logic [7:0] ty, int src, int snk);
        wait_drained();
        apb_write({crc8fr_pkg::REG_START_MARKER, 2'b00}, mk);
        marker_cfg = mk;
        apb_write({crc8fr_pkg::REG_COMMAND_TYPE, 2'b00}, ty);
        cmd_type_cfg  = ty;
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                frame_parse_step({in_ch.cmd, in_ch.rx_byte});
            // hold the beat until accepted
            if (!in_ch.valid || in_ch.ready)
            begin
                if (link_feed.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_beat = link_feed.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.cmd     <= next_beat.pop;
                    in_ch.rx_byte <= next_beat.data;
                end
                else
                begin
                    in_ch.valid   <= 1'b0;
                    in_ch.cmd     <= 1'($urandom);
                    in_ch.rx_byte <= 8'($urandom);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_report();
            out_ch.ready <= $urandom_range(99) >= snk_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** crc8_frame_receiver_with_command_fifo: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = 1'b0;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_phase(crc8fr_pkg::START_MARKER_RESET, crc8fr_pkg::COMMAND_TYPE_RESET, 0, 0);
        feed(1'b1, 8'hFF);
        feed_frame(cmd_type_cfg, 16'(CMD_BYTES), 1'b0);
        feed_frame(cmd_type_cfg, 16'd0, 1'b0);
        feed_frame(8'h00, 16'(MAX_PAYLOAD + 1), 1'b0);
        feed_frame(8'hFF, 16'hFFFF, 1'b0);
        feed(1'b1, 8'h00);
        feed(1'b1, 8'h5A);
        feed_random(115, 30);

        set_phase(8'h00, 8'hFF, 52, 0);
        feed_random(115, 35);

        set_phase(8'hFF, 8'h00, 0, 52);
        feed_frame(8'($urandom), 16'(MAX_PAYLOAD), 1'b0);
        feed_random(115, 25);

        set_phase(8'($urandom), 8'($urandom), 37, 37);
        feed_random(115, 30);

        // fill the queue past capacity, then keep it near full
        set_phase(crc8fr_pkg::START_MARKER_RESET, crc8fr_pkg::COMMAND_TYPE_RESET, 0, 0);
        repeat (17) feed_frame(cmd_type_cfg, 16'(CMD_BYTES), 1'b0);
        feed_random(115, 10);

        set_phase(8'($urandom), 8'($urandom), 37, 37);
        feed_random(115, 60);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("** crc8_frame_receiver_with_command_fifo: PASSED **");
        else
            $display("** crc8_frame_receiver_with_command_fifo: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ crc8_frame_receiver_with_command_fifo.f @@
hw/rtl/crc8fr_pkg.sv
hw/rtl/crc8fr_if.sv
hw/rtl/crc8fr_parser.sv
hw/rtl/crc8fr_cmd_queue.sv
hw/rtl/crc8_frame_receiver_with_command_fifo.sv
bench/tb_crc8_frame_receiver_with_command_fifo.sv
